/* src/kmer_hash_graph_table_macros.svh */
// Assertion macros shared by the checker of the k-mer graph table.
`ifndef KMER_HASH_GRAPH_TABLE_MACROS_SVH
`define KMER_HASH_GRAPH_TABLE_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define KHGT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("khgt check failed");

// Next-cycle implication, off while reset is asserted.
`define KHGT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("khgt check failed");

// Next-cycle implication that is also checked across reset.
`define KHGT_ASSERT_RST_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("khgt reset check failed");

`endif

/* src/khgt_pkg.sv */
// Shared types, codes and constants of the k-mer graph table.
package khgt_pkg;

  localparam int TABLE_ENTRIES_DEF   = 1024;
  localparam int DIRECTORY_SLOTS_DEF = 2048;
  localparam int ALPHABET_SIZE       = 4;
  localparam int BITS_PER_CHAR       = 2;

  localparam int WORD_W     = 64;
  localparam int CHAR_W     = BITS_PER_CHAR;
  localparam int FLAG_W     = ALPHABET_SIZE + 1;
  localparam int MAX_K      = WORD_W / BITS_PER_CHAR;
  localparam int SHIFT_W    = 7;
  localparam int KLEN_W     = 6;
  localparam int KLEN_RESET = 31;
  localparam int NODE_W     = 13;
  localparam int DEG_W      = 3;
  localparam int LEFT_W     = $clog2(ALPHABET_SIZE + 1);
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 16;

  localparam logic [WORD_W-1:0] CHAR_MASK = WORD_W'((1 << BITS_PER_CHAR) - 1);
  localparam logic [WORD_W-1:0] HASH_MUL  = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [FLAG_W-1:0] SRC_BIT   = FLAG_W'(1) << ALPHABET_SIZE;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_OUTDEG = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    STAT_NEW   = 2'd0,
    STAT_FOUND = 2'd1,
    STAT_MISS  = 2'd2,
    STAT_FULL  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_NODE_CHK,
    ST_HASH,
    ST_DIR_RD,
    ST_DIR_CHK,
    ST_PREF_CHK,
    ST_INSERT,
    ST_EMIT
  } state_t;

endpackage

/* src/khgt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module khgt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/khgt_hash.sv */
// Multiplicative hash of a 64-bit prefix, one 32x32 multiplier used three times.
module khgt_hash #(
  parameter int DIRECTORY_SLOTS = khgt_pkg::DIRECTORY_SLOTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [khgt_pkg::WORD_W-1:0]        key,
  output logic                               done,
  output logic [$clog2(DIRECTORY_SLOTS)-1:0] slot
);
  import khgt_pkg::*;

  localparam int SLOT_W = $clog2(DIRECTORY_SLOTS);

  logic              busy_r, busy_nxt;
  logic [1:0]        step_r, step_nxt;
  logic [WORD_W-1:0] key_r;
  logic [63:0]       prod_r;
  logic [31:0]       acc_r, acc_nxt;
  logic [31:0]       mul_a, mul_b;
  logic [31:0]       sum;

  // Operand selection: low x low, low x high, high x low.
  always_comb begin
    case (step_r)
      2'd0: begin
        mul_a = key_r[31:0];
        mul_b = HASH_MUL[31:0];
      end
      2'd1: begin
        mul_a = key_r[31:0];
        mul_b = HASH_MUL[63:32];
      end
      default: begin
        mul_a = key_r[63:32];
        mul_b = HASH_MUL[31:0];
      end
    endcase
  end

  // Accumulate bits 63:32 of the 64-bit product.
  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    acc_nxt  = acc_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = 2'd0;
    end else if (busy_r) begin
      step_nxt = step_r + 2'd1;
      case (step_r)
        2'd1:    acc_nxt = prod_r[63:32];
        2'd2:    acc_nxt = acc_r + prod_r[31:0];
        2'd3:    busy_nxt = 1'b0;
        default: acc_nxt = acc_r;
      endcase
    end
  end

  assign sum  = acc_r + prod_r[31:0];
  assign done = busy_r && (step_r == 2'd3);
  assign slot = sum[SLOT_W-1:0];

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
  end

  // Datapath registers, the product registered before it is added.
  always_ff @(posedge clk) begin
    if (start) begin
      key_r <= key;
    end
    prod_r <= mul_a * mul_b;
    acc_r  <= acc_nxt;
  end

endmodule

/* src/kmer_hash_graph_table.sv */
// Top level of the k-mer graph table: sequencer, tables and result register.
//
//  Channel  Signals                                   Item
//  in_      tvalid tready tdata[79:0] tuser[1:0]      one query or insert
//  out_     tvalid tready tdata[15:0] tuser[1:0] tlast one result, up to four per input
//  cfg_     wr_en wr_data[5:0]                         k-mer length
//
// After reset every slot of the hash directory is swept clear;
// no item is accepted meanwhile. One input is worked on at a time: the hash
// runs on the shared 32x32 multiplier, each probe reads the directory and,
// for a live entry, the prefix RAM, then one result is sent (ALPHABET_SIZE
// for a new entry). A query that needs no lookup goes straight to its result. Results wait
// in an output register; a stalled output holds the block in its last state.
module kmer_hash_graph_table #(
  parameter int TABLE_ENTRIES   = khgt_pkg::TABLE_ENTRIES_DEF,
  parameter int DIRECTORY_SLOTS = khgt_pkg::DIRECTORY_SLOTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // kmer_word[63:0], kmer_valid[64], sequence_start[65], node_in[78:66]
  input  logic [khgt_pkg::IN_DATA_W-1:0]    in_tdata,
  // kind[1:0]
  input  logic [1:0]                        in_tuser,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // node_out[12:0], degree[15:13]
  output logic [khgt_pkg::OUT_DATA_W-1:0]   out_tdata,
  // status[1:0]
  output logic [1:0]                        out_tuser,
  output logic                              out_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic                              cfg_wr_en,
  input  logic [khgt_pkg::KLEN_W-1:0]       cfg_wr_data
);
  import khgt_pkg::*;

  localparam int ENTRY_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
  localparam int SLOT_W  = $clog2(DIRECTORY_SLOTS);

  state_t state_r, state_nxt;

  logic [KLEN_W-1:0]  klen_r, klen_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               prev_r, prev_nxt;
  logic [SLOT_W-1:0]  clr_r, clr_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic [1:0]         kind_r, kind_nxt;
  logic [WORD_W-1:0]  key_r, key_nxt;
  logic [CHAR_W-1:0]  c_r, c_nxt;
  logic [NODE_W-1:0]  node_r, node_nxt;
  logic [ENTRY_W-1:0] e_r, e_nxt;
  logic [SLOT_W-1:0]  slot_r, slot_nxt;
  logic [SLOT_W-1:0]  probe_r, probe_nxt;
  logic [NODE_W-1:0]  res_node_r, res_node_nxt;
  logic [1:0]         res_stat_r, res_stat_nxt;
  logic [DEG_W-1:0]   res_deg_r, res_deg_nxt;
  logic [LEFT_W-1:0]  left_r, left_nxt;
  logic [NODE_W-1:0]  out_node_r, out_node_nxt;
  logic [1:0]         out_stat_r, out_stat_nxt;
  logic [DEG_W-1:0]   out_deg_r, out_deg_nxt;
  logic               out_last_r, out_last_nxt;

  // Input fields and the character split of the incoming k-mer.
  logic [WORD_W-1:0]  in_word;
  logic               in_kvalid, in_start;
  logic [NODE_W-1:0]  in_node;
  logic [SHIFT_W-1:0] klen_c, shift;
  logic [CHAR_W-1:0]  in_c;
  logic [WORD_W-1:0]  in_key;
  logic               in_ok;

  assign in_word   = in_tdata[WORD_W-1:0];
  assign in_kvalid = in_tdata[WORD_W];
  assign in_start  = in_tdata[WORD_W+1];
  assign in_node   = in_tdata[WORD_W+2+NODE_W-1:WORD_W+2];

  always_comb begin
    if (klen_r == '0) begin
      klen_c = SHIFT_W'(1);
    end else if (32'(klen_r) > MAX_K) begin
      klen_c = SHIFT_W'(MAX_K);
    end else begin
      klen_c = SHIFT_W'(klen_r);
    end
  end

  assign shift  = SHIFT_W'(BITS_PER_CHAR * (32'(klen_c) - 1));
  assign in_c   = CHAR_W'(in_word >> shift);
  assign in_key = in_word & ~(CHAR_MASK << shift);
  assign in_ok  = in_kvalid && (32'(in_c) < ALPHABET_SIZE);

  // Memories.
  logic                     dir_we;
  logic [SLOT_W-1:0]        dir_waddr, dir_raddr;
  logic [CNT_W-1:0]         dir_wdata, dir_rdata;
  logic                     ent_we, flag_we;
  logic [ENTRY_W-1:0]       ent_waddr, ent_raddr;
  logic [WORD_W-1:0]        pref_wdata, pref_rdata;
  logic [FLAG_W-1:0]        flag_wdata, flag_rdata;

  khgt_ram #(.WIDTH(CNT_W), .DEPTH(DIRECTORY_SLOTS)) u_dir (
    .clk(clk), .we(dir_we), .waddr(dir_waddr), .wdata(dir_wdata),
    .raddr(dir_raddr), .rdata(dir_rdata)
  );

  khgt_ram #(.WIDTH(WORD_W), .DEPTH(TABLE_ENTRIES)) u_pref (
    .clk(clk), .we(ent_we), .waddr(ent_waddr), .wdata(pref_wdata),
    .raddr(ent_raddr), .rdata(pref_rdata)
  );

  khgt_ram #(.WIDTH(FLAG_W), .DEPTH(TABLE_ENTRIES)) u_flag (
    .clk(clk), .we(flag_we), .waddr(ent_waddr), .wdata(flag_wdata),
    .raddr(ent_raddr), .rdata(flag_rdata)
  );

  // Shared hash unit.
  logic              hash_start, hash_done;
  logic [WORD_W-1:0] hash_key;
  logic [SLOT_W-1:0] hash_slot;

  khgt_hash #(.DIRECTORY_SLOTS(DIRECTORY_SLOTS)) u_hash (
    .clk(clk), .rst_n(rst_n), .start(hash_start), .key(hash_key),
    .done(hash_done), .slot(hash_slot)
  );

  // Helper values for the probe and the outdegree query.
  logic [CNT_W-1:0]  dir_v_m1;
  logic [4:0]        pop;
  logic [WORD_W-1:0] next_key;

  assign dir_v_m1 = dir_rdata - CNT_W'(1);
  assign next_key = (pref_rdata | (WORD_W'(c_r) << shift)) >> BITS_PER_CHAR;

  always_comb begin
    pop = '0;
    for (int i = 0; i < ALPHABET_SIZE; i++) begin
      pop = pop + 5'(flag_rdata[i]);
    end
  end

  // Sequencer: next state, table writes and the result to send.
  always_comb begin
    logic miss, hit, advance, have_empty;

    state_nxt     = state_r;
    klen_nxt      = cfg_wr_en ? cfg_wr_data : klen_r;
    count_nxt     = count_r;
    prev_nxt      = prev_r;
    clr_nxt       = clr_r;
    kind_nxt      = kind_r;
    key_nxt       = key_r;
    c_nxt         = c_r;
    node_nxt      = node_r;
    e_nxt         = e_r;
    slot_nxt      = slot_r;
    probe_nxt     = probe_r;
    res_node_nxt  = res_node_r;
    res_stat_nxt  = res_stat_r;
    res_deg_nxt   = res_deg_r;
    left_nxt      = left_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_node_nxt  = out_node_r;
    out_stat_nxt  = out_stat_r;
    out_deg_nxt   = out_deg_r;
    out_last_nxt  = out_last_r;

    in_tready  = 1'b0;
    hash_start = 1'b0;
    hash_key   = in_key;
    dir_we     = 1'b0;
    dir_waddr  = slot_r;
    dir_wdata  = '0;
    dir_raddr  = slot_r;
    ent_we     = 1'b0;
    flag_we    = 1'b0;
    ent_waddr  = e_r;
    ent_raddr  = e_r;
    pref_wdata = key_r;
    flag_wdata = '0;

    miss       = 1'b0;
    hit        = 1'b0;
    advance    = 1'b0;
    have_empty = 1'b0;

    case (state_r)
      // Sweep the directory empty after reset.
      ST_CLEAR: begin
        dir_we    = 1'b1;
        dir_waddr = clr_r;
        clr_nxt   = clr_r + SLOT_W'(1);
        if (clr_r == SLOT_W'(DIRECTORY_SLOTS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      // Take an item and decide what it needs.
      ST_IDLE: begin
        in_tready = 1'b1;
        ent_raddr = ENTRY_W'((32'(in_node) - 1) / ALPHABET_SIZE);
        if (in_tvalid) begin
          kind_nxt     = in_tuser;
          key_nxt      = in_key;
          c_nxt        = in_c;
          node_nxt     = in_node;
          res_node_nxt = '0;
          res_stat_nxt = STAT_MISS;
          res_deg_nxt  = '0;
          left_nxt     = LEFT_W'(1);
          state_nxt    = ST_EMIT;
          case (in_tuser)
            KIND_INSERT: begin
              if (!in_ok) begin
                prev_nxt = 1'b0;
              end else begin
                prev_nxt   = in_start ? 1'b0 : prev_r;
                hash_start = 1'b1;
                state_nxt  = ST_HASH;
              end
            end
            KIND_LOOKUP: begin
              if (in_ok) begin
                hash_start = 1'b1;
                state_nxt  = ST_HASH;
              end
            end
            KIND_OUTDEG: begin
              if (in_node != '0 &&
                  32'(in_node) <= 32'(count_r) * ALPHABET_SIZE) begin
                c_nxt     = CHAR_W'((32'(in_node) - 1) % ALPHABET_SIZE);
                state_nxt = ST_NODE_CHK;
              end
            end
            default: begin
              state_nxt = ST_EMIT;
            end
          endcase
        end
      end

      // Outdegree: the node must be real, then hash its successor prefix.
      ST_NODE_CHK: begin
        if (((flag_rdata >> c_r) & FLAG_W'(1)) == '0) begin
          miss         = 1'b0;
          res_node_nxt = '0;
          res_stat_nxt = STAT_MISS;
          res_deg_nxt  = '0;
          left_nxt     = LEFT_W'(1);
          state_nxt    = ST_EMIT;
        end else begin
          key_nxt    = next_key;
          hash_key   = next_key;
          hash_start = 1'b1;
          state_nxt  = ST_HASH;
        end
      end

      ST_HASH: begin
        if (hash_done) begin
          slot_nxt  = hash_slot;
          probe_nxt = '0;
          state_nxt = ST_DIR_RD;
        end
      end

      ST_DIR_RD: begin
        state_nxt = ST_DIR_CHK;
      end

      // Directory slot: empty ends the probe, a live entry needs its prefix.
      ST_DIR_CHK: begin
        if (dir_rdata == '0) begin
          miss       = 1'b1;
          have_empty = 1'b1;
        end else if (dir_v_m1 < count_r) begin
          ent_raddr = ENTRY_W'(dir_v_m1);
          e_nxt     = ENTRY_W'(dir_v_m1);
          state_nxt = ST_PREF_CHK;
        end else begin
          advance = 1'b1;
        end
      end

      ST_PREF_CHK: begin
        if (pref_rdata == key_r) begin
          hit = 1'b1;
        end else begin
          advance = 1'b1;
        end
      end

      // New entry: store prefix and flags, link the directory slot.
      ST_INSERT: begin
        ent_we       = 1'b1;
        flag_we      = 1'b1;
        ent_waddr    = ENTRY_W'(count_r);
        pref_wdata   = key_r;
        flag_wdata   = (FLAG_W'(1) << c_r) | (prev_r ? '0 : SRC_BIT);
        dir_we       = 1'b1;
        dir_waddr    = slot_r;
        dir_wdata    = count_r + CNT_W'(1);
        count_nxt    = count_r + CNT_W'(1);
        prev_nxt     = 1'b1;
        res_node_nxt = NODE_W'(32'(count_r) * ALPHABET_SIZE + 1);
        res_stat_nxt = STAT_NEW;
        res_deg_nxt  = '0;
        left_nxt     = LEFT_W'(ALPHABET_SIZE);
        state_nxt    = ST_EMIT;
      end

      // Hand results to the output register, one per free slot.
      ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_node_nxt  = res_node_r;
          out_stat_nxt  = res_stat_r;
          out_deg_nxt   = res_deg_r;
          out_last_nxt  = (left_r == LEFT_W'(1));
          res_node_nxt  = res_node_r + NODE_W'(1);
          left_nxt      = left_r - LEFT_W'(1);
          if (left_r == LEFT_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Step to the next slot, or give up once every slot was seen.
    if (advance) begin
      if (probe_r == SLOT_W'(DIRECTORY_SLOTS - 1)) begin
        miss = 1'b1;
      end else begin
        slot_nxt  = slot_r + SLOT_W'(1);
        probe_nxt = probe_r + SLOT_W'(1);
        state_nxt = ST_DIR_RD;
      end
    end

    // Prefix not stored.
    if (miss) begin
      res_node_nxt = '0;
      res_stat_nxt = STAT_MISS;
      res_deg_nxt  = '0;
      left_nxt     = LEFT_W'(1);
      state_nxt    = ST_EMIT;
      case (kind_r)
        KIND_INSERT: begin
          if (count_r >= CNT_W'(TABLE_ENTRIES) || !have_empty) begin
            prev_nxt     = 1'b0;
            res_stat_nxt = STAT_FULL;
          end else begin
            state_nxt = ST_INSERT;
          end
        end
        KIND_OUTDEG: begin
          res_node_nxt = node_r;
          res_stat_nxt = STAT_FOUND;
        end
        default: begin
          res_stat_nxt = STAT_MISS;
        end
      endcase
    end

    // Prefix stored at entry e_r; its flags are on the flag RAM output.
    if (hit) begin
      res_node_nxt = NODE_W'(32'(e_r) * ALPHABET_SIZE + 32'(c_r) + 1);
      res_stat_nxt = STAT_FOUND;
      res_deg_nxt  = '0;
      left_nxt     = LEFT_W'(1);
      state_nxt    = ST_EMIT;
      case (kind_r)
        KIND_INSERT: begin
          flag_we    = 1'b1;
          ent_waddr  = e_r;
          flag_wdata = (flag_rdata | (FLAG_W'(1) << c_r)) & (prev_r ? ~SRC_BIT : '1);
          prev_nxt   = 1'b1;
        end
        KIND_LOOKUP: begin
          if (((flag_rdata >> c_r) & FLAG_W'(1)) == '0) begin
            res_node_nxt = '0;
            res_stat_nxt = STAT_MISS;
          end
        end
        default: begin
          res_node_nxt = node_r;
          res_deg_nxt  = DEG_W'(pop);
        end
      endcase
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      klen_r      <= KLEN_W'(KLEN_RESET);
      count_r     <= '0;
      prev_r      <= 1'b0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      klen_r      <= klen_nxt;
      count_r     <= count_nxt;
      prev_r      <= prev_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    key_r      <= key_nxt;
    c_r        <= c_nxt;
    node_r     <= node_nxt;
    e_r        <= e_nxt;
    slot_r     <= slot_nxt;
    probe_r    <= probe_nxt;
    res_node_r <= res_node_nxt;
    res_stat_r <= res_stat_nxt;
    res_deg_r  <= res_deg_nxt;
    left_r     <= left_nxt;
    out_node_r <= out_node_nxt;
    out_stat_r <= out_stat_nxt;
    out_deg_r  <= out_deg_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_deg_r, out_node_r};
  assign out_tuser  = out_stat_r;
  assign out_tlast  = out_last_r;

endmodule

/* src/khgt_checker.sv */
// Port-level checks of the k-mer graph table, bound to its top level.
`include "kmer_hash_graph_table_macros.svh"

module khgt_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic                            out_tlast,
  input logic [1:0]                      out_tuser,
  input logic [khgt_pkg::OUT_DATA_W-1:0] out_tdata
);
  import khgt_pkg::*;

  // A stalled result keeps its payload.
  `KHGT_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // Nothing comes out in the cycle after reset.
  `KHGT_ASSERT_RST_NEXT(a_out_reset, !rst_n, !out_tvalid)

  // While a run of results is still open no new item is taken.
  `KHGT_ASSERT_IMP(a_busy_run, out_tvalid && !out_tlast, !in_tready)

  // Only an outdegree result that found its node carries a degree.
  `KHGT_ASSERT_IMP(a_deg_found, out_tvalid && out_tdata[15:13] != 3'd0, out_tuser == STAT_FOUND)

  // Misses and a full table report no node.
  `KHGT_ASSERT_IMP(a_miss_zero, out_tvalid && (out_tuser == STAT_MISS || out_tuser == STAT_FULL),
                   out_tdata[12:0] == 13'd0)

endmodule

bind kmer_hash_graph_table khgt_checker u_khgt_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tlast(out_tlast),
  .out_tuser(out_tuser), .out_tdata(out_tdata)
);
